// ===== rtl/core/lpf_pkg.sv =====
// Shared constants and types for the Lennard-Jones pair force pipeline.
`default_nettype none

package lpf_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_TYPES_DEF  = 2;
  localparam int unsigned COORD_FRAC_DEF = 16;

  // Field widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned COEF_W  = 48;
  localparam int unsigned OUT_W   = 48;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_REGS = 4'd8;

  // Latency of one pipelined 64x64 multiply, shift and clip unit
  localparam int unsigned MUL_LAT = 4;

  // Clip limits and the reciprocal of three used for the energy terms
  localparam logic [63:0] MAG62      = 64'h4000_0000_0000_0000;
  localparam logic [63:0] POS47      = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] NEG47      = 64'h0000_8000_0000_0000;
  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DIV3_MAGIC = 64'h5555_5555_5555_5556;

  // Per-pair side data that travels down the pipeline next to the arithmetic
  typedef struct packed {
    logic [2:0][32:0] ad;    // displacement magnitudes
    logic [2:0]       dneg;  // displacement signs
    logic [47:0]      a;     // repulsive coefficient
    logic [47:0]      b;     // attractive coefficient
    logic             en;    // energy wanted
    logic             zero;  // coincident atoms
    logic             neg;   // sign of the force scalar
    logic             eneg;  // sign of the energy scalar
    logic             sat;   // running clip flag
  } ctx_t;

endpackage

`default_nettype wire

// ===== rtl/core/lpf_delay.sv =====
// Enabled shift line that aligns side data with the arithmetic units.
`default_nettype none

module lpf_delay #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] stg_q [DEPTH];

  // Shift one place on each advance
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        stg_q[i] <= stg_q[i-1];
      end
    end
  end

  assign q_o = stg_q[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/core/lpf_mulsat.sv =====
// Pipelined 64x64 multiply from 32x32 partial products, right shift and clip.
`default_nettype none

module lpf_mulsat #(
  parameter int unsigned SH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  input  wire logic [63:0] lim_i,
  output logic      [63:0] res_o,
  output logic             sat_o
);

  logic [63:0]  p00_q, p01_q, p10_q, p11_q, lim1_q;
  logic [63:0]  lo_q, hi_q, lim2_q;
  logic [64:0]  mid_q;
  logic [127:0] prod_q;
  logic [63:0]  lim3_q;
  logic [127:0] shifted;
  logic         over;

  assign shifted = prod_q >> SH;
  assign over    = (|shifted[127:64]) || (shifted[63:0] > lim3_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // partial products
      p00_q  <= a_i[31:0]  * b_i[31:0];
      p01_q  <= a_i[31:0]  * b_i[63:32];
      p10_q  <= a_i[63:32] * b_i[31:0];
      p11_q  <= a_i[63:32] * b_i[63:32];
      lim1_q <= lim_i;
      // fold the cross terms
      mid_q  <= {1'b0, p01_q} + {1'b0, p10_q};
      lo_q   <= p00_q;
      hi_q   <= p11_q;
      lim2_q <= lim1_q;
      // full product
      prod_q <= {hi_q, lo_q} + ({63'd0, mid_q} << 32);
      lim3_q <= lim2_q;
      // shift and clip
      res_o  <= over ? lim3_q : shifted[63:0];
      sat_o  <= over;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lpf_recip.sv =====
// Pipelined restoring divider for floor(2^K / s), one quotient bit per stage.
`default_nettype none

module lpf_recip #(
  parameter int unsigned K = 64
) (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [65:0] s_i,
  output logic      [63:0] r2_o,
  output logic             sat_o
);

  localparam int unsigned QW = K + 1;
  localparam logic [63:0] ALL_ONES_64 = '1;

  logic [65:0]   rem_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [65:0]   div_q [QW-1];
  logic          over;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [65:0]   rem_in, div_in;
    logic [QW-1:0] quo_in;
    logic [66:0]   trial, diff;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign div_in = s_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign div_in = div_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    // the dividend is a single one at its top bit
    assign trial = {rem_in, (i == 0) ? 1'b1 : 1'b0};
    assign diff  = trial - {1'b0, div_in};
    assign take  = (trial >= {1'b0, div_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= take ? diff[65:0] : trial[65:0];
        quo_q[i] <= {quo_in[QW-2:0], take};
      end
    end

    if (i < QW - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          div_q[i] <= div_in;
        end
      end
    end
  end

  // Clip a quotient that needs more than 64 bits
  if (QW > 64) begin : g_wide
    assign over = |quo_q[QW-1][QW-1:64];
  end else begin : g_narrow
    assign over = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r2_o  <= over ? ALL_ONES_64 : 64'(quo_q[QW-1]);
      sat_o <= over;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lj_pair_force_unit.sv =====
// Lennard-Jones 12-6 pair force and energy, one atom pair per cycle when not stalled.
//
//  channel  | direction | payload                                   | beat when
//  s_axis   | in        | tdata coords, tuser types and energy flag | tvalid & tready
//  m_axis   | out       | tdata forces and energy, tuser flags      | tvalid & tready
//  cfg      | in        | index and 48-bit coefficient              | cfg_valid_i & cfg_ready_o
//
// One pair enters per cycle unless the output stalls; each result passes through
// the one-bit-per-stage reciprocal divider and six four-stage multiply units in turn.
// Reset clears the coefficients and all valid bits; no clearing pass is needed.
// An output beat that is not taken stalls the whole pipeline in place; nothing drops.
// Configuration is always ready and takes effect for pairs accepted afterwards.
`default_nettype none

module lj_pair_force_unit
  import lpf_pkg::*;
#(
  parameter int unsigned NUM_TYPES       = NUM_TYPES_DEF,
  parameter int unsigned COORD_FRAC_BITS = COORD_FRAC_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // first_x, first_y, first_z, second_x, second_y, second_z (32 bits each)
  input  wire logic [191:0]         s_axis_tdata,
  // first_type, second_type, energy_enable
  input  wire logic [2:0]           s_axis_tuser,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // force_x, force_y, force_z, pair_energy (48 bits each)
  output logic [191:0]              m_axis_tdata,
  // zero_distance, saturated
  output logic [1:0]                m_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [COEF_W-1:0]    cfg_data_i
);

  localparam int unsigned K         = 2 * COORD_FRAC_BITS + 32;
  localparam int unsigned RECIP_LAT = K + 2;
  localparam int unsigned PIPE_LAT  = 4 + RECIP_LAT + 6 * MUL_LAT + 3;
  localparam int unsigned CTX_W     = $bits(ctx_t);

  logic adv;
  logic [PIPE_LAT-1:0] vld_q;
  logic [3:0][COEF_W-1:0] rep_q, att_q;

  assign adv           = !vld_q[PIPE_LAT-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[PIPE_LAT-1];
  assign cfg_ready_o   = 1'b1;

  // Coefficient registers; writes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q <= '0;
      att_q <= '0;
    end else if (cfg_valid_i && (cfg_index_i < CFG_NUM_REGS)) begin
      if (cfg_index_i[0]) begin
        att_q[cfg_index_i[2:1]] <= cfg_data_i;
      end else begin
        rep_q[cfg_index_i[2:1]] <= cfg_data_i;
      end
    end
  end

  // Valid bits follow the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
    end
  end

  // Stage 1: displacement and coefficient pick
  logic [1:0] t1w, t2w, t1c, t2c;
  logic [2:0][32:0] s1_d_q;
  logic [COEF_W-1:0] s1_a_q, s1_b_q;
  logic s1_en_q;

  assign t1w = {1'b0, s_axis_tuser[0]};
  assign t2w = {1'b0, s_axis_tuser[1]};
  assign t1c = (t1w >= 2'(NUM_TYPES)) ? 2'(NUM_TYPES - 1) : t1w;
  assign t2c = (t2w >= 2'(NUM_TYPES)) ? 2'(NUM_TYPES - 1) : t2w;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s1_d_q[k] <= {s_axis_tdata[k*32+31], s_axis_tdata[k*32 +: 32]}
                   - {s_axis_tdata[(k+3)*32+31], s_axis_tdata[(k+3)*32 +: 32]};
      end
      s1_a_q  <= rep_q[{t1c[0], t2c[0]}];
      s1_b_q  <= att_q[{t1c[0], t2c[0]}];
      s1_en_q <= s_axis_tuser[2];
    end
  end

  // Stage 2: magnitudes and signs
  ctx_t s2_q, s3_q, s4_q;
  logic [2:0][65:0] sq_q;
  logic [65:0] s_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s2_q.ad[k]   <= s1_d_q[k][32] ? (33'd0 - s1_d_q[k]) : s1_d_q[k];
        s2_q.dneg[k] <= s1_d_q[k][32];
      end
      s2_q.a    <= s1_a_q;
      s2_q.b    <= s1_b_q;
      s2_q.en   <= s1_en_q;
      s2_q.zero <= (s1_d_q == '0);
      s2_q.neg  <= 1'b0;
      s2_q.eneg <= 1'b0;
      s2_q.sat  <= 1'b0;
      // Stage 3: squares
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= s2_q.ad[k] * s2_q.ad[k];
      end
      s3_q <= s2_q;
      // Stage 4: squared distance
      s_q  <= sq_q[0] + sq_q[1] + sq_q[2];
      s4_q <= s3_q;
    end
  end

  // Reciprocal square
  logic [63:0] r2_r;
  logic rsat_r;
  ctx_t ctx_r, ctx_rm;

  lpf_recip #(.K(K)) u_recip (
    .clk_i(clk_i), .en_i(adv), .s_i(s_q), .r2_o(r2_r), .sat_o(rsat_r)
  );
  lpf_delay #(.WIDTH(CTX_W), .DEPTH(RECIP_LAT)) u_dly_ctx_r (
    .clk_i(clk_i), .en_i(adv), .d_i(s4_q), .q_o(ctx_r)
  );

  always_comb begin
    ctx_rm     = ctx_r;
    ctx_rm.sat = ctx_r.sat | rsat_r;
  end

  // r^-4
  logic [63:0] r4, r2_4;
  logic sat4;
  ctx_t ctx_4, ctx_4m;

  lpf_mulsat #(.SH(32)) u_mul_r4 (
    .clk_i(clk_i), .en_i(adv), .a_i(r2_r), .b_i(r2_r), .lim_i(ALL_ONES),
    .res_o(r4), .sat_o(sat4)
  );
  lpf_delay #(.WIDTH(CTX_W), .DEPTH(MUL_LAT)) u_dly_ctx_4 (
    .clk_i(clk_i), .en_i(adv), .d_i(ctx_rm), .q_o(ctx_4)
  );
  lpf_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_dly_r2_4 (
    .clk_i(clk_i), .en_i(adv), .d_i(r2_r), .q_o(r2_4)
  );

  always_comb begin
    ctx_4m     = ctx_4;
    ctx_4m.sat = ctx_4.sat | sat4;
  end

  // r^-6
  logic [63:0] r6, r2_6;
  logic sat6;
  ctx_t ctx_6, ctx_6m;

  lpf_mulsat #(.SH(32)) u_mul_r6 (
    .clk_i(clk_i), .en_i(adv), .a_i(r4), .b_i(r2_4), .lim_i(ALL_ONES),
    .res_o(r6), .sat_o(sat6)
  );
  lpf_delay #(.WIDTH(CTX_W), .DEPTH(MUL_LAT)) u_dly_ctx_6 (
    .clk_i(clk_i), .en_i(adv), .d_i(ctx_4m), .q_o(ctx_6)
  );
  lpf_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_dly_r2_6 (
    .clk_i(clk_i), .en_i(adv), .d_i(r2_4), .q_o(r2_6)
  );

  always_comb begin
    ctx_6m     = ctx_6;
    ctx_6m.sat = ctx_6.sat | sat6;
  end

  // Repulsive term A * r^-6
  logic [63:0] ar, r2_a, r6_a;
  logic sata;
  ctx_t ctx_a;

  lpf_mulsat #(.SH(24)) u_mul_ar (
    .clk_i(clk_i), .en_i(adv), .a_i(64'(ctx_6m.a)), .b_i(r6), .lim_i(MAG62),
    .res_o(ar), .sat_o(sata)
  );
  lpf_delay #(.WIDTH(CTX_W), .DEPTH(MUL_LAT)) u_dly_ctx_a (
    .clk_i(clk_i), .en_i(adv), .d_i(ctx_6m), .q_o(ctx_a)
  );
  lpf_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_dly_r2_a (
    .clk_i(clk_i), .en_i(adv), .d_i(r2_6), .q_o(r2_a)
  );
  lpf_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_dly_r6_a (
    .clk_i(clk_i), .en_i(adv), .d_i(r6), .q_o(r6_a)
  );

  // Stage E: inner difference and energy dividends
  logic [63:0] bs, e_mag_q, e_eax_q, e_ebx_q, e_r2_q, e_r6_q;
  ctx_t e_ctx_q, ctx_am;

  assign bs = {8'd0, ctx_a.b, 8'd0};

  always_comb begin
    ctx_am     = ctx_a;
    ctx_am.sat = ctx_a.sat | sata;
    ctx_am.neg = (ar < bs);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_ctx_q <= ctx_am;
      e_mag_q <= (ar < bs) ? (bs - ar) : (ar - bs);
      e_eax_q <= ar >> 2;
      e_ebx_q <= {9'd0, ctx_a.b, 7'd0};
      e_r2_q  <= r2_a;
      e_r6_q  <= r6_a;
    end
  end

  // Force scalar first product and division of the energy terms by three
  logic [63:0] fl, ea, eb, r2_f, r6_f;
  logic satf;
  ctx_t ctx_f;

  lpf_mulsat #(.SH(32)) u_mul_fl (
    .clk_i(clk_i), .en_i(adv), .a_i(e_r6_q), .b_i(e_mag_q), .lim_i(MAG62),
    .res_o(fl), .sat_o(satf)
  );
  lpf_mulsat #(.SH(64)) u_div_ea (
    .clk_i(clk_i), .en_i(adv), .a_i(e_eax_q), .b_i(DIV3_MAGIC), .lim_i(ALL_ONES),
    .res_o(ea), .sat_o()
  );
  lpf_mulsat #(.SH(64)) u_div_eb (
    .clk_i(clk_i), .en_i(adv), .a_i(e_ebx_q), .b_i(DIV3_MAGIC), .lim_i(ALL_ONES),
    .res_o(eb), .sat_o()
  );
  lpf_delay #(.WIDTH(CTX_W), .DEPTH(MUL_LAT)) u_dly_ctx_f (
    .clk_i(clk_i), .en_i(adv), .d_i(e_ctx_q), .q_o(ctx_f)
  );
  lpf_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_dly_r2_f (
    .clk_i(clk_i), .en_i(adv), .d_i(e_r2_q), .q_o(r2_f)
  );
  lpf_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_dly_r6_f (
    .clk_i(clk_i), .en_i(adv), .d_i(e_r6_q), .q_o(r6_f)
  );

  // Stage G: energy sign and magnitude
  logic [63:0] g_fl_q, g_emag_q, g_r2_q, g_r6_q;
  ctx_t g_ctx_q, ctx_fm;

  always_comb begin
    ctx_fm      = ctx_f;
    ctx_fm.sat  = ctx_f.sat | satf;
    ctx_fm.eneg = (ea < eb);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_fl_q   <= fl;
      g_ctx_q  <= ctx_fm;
      g_emag_q <= (ea < eb) ? (eb - ea) : (ea - eb);
      g_r2_q   <= r2_f;
      g_r6_q   <= r6_f;
    end
  end

  // Force scalar and pair energy
  logic [63:0] fp, eng, eng_h;
  logic satp, sate, esat_h;
  ctx_t ctx_p, ctx_pm, ctx_h;

  lpf_mulsat #(.SH(32)) u_mul_fp (
    .clk_i(clk_i), .en_i(adv), .a_i(g_fl_q), .b_i(g_r2_q), .lim_i(MAG62),
    .res_o(fp), .sat_o(satp)
  );
  lpf_mulsat #(.SH(40)) u_mul_en (
    .clk_i(clk_i), .en_i(adv), .a_i(g_r6_q), .b_i(g_emag_q),
    .lim_i(g_ctx_q.eneg ? NEG47 : POS47), .res_o(eng), .sat_o(sate)
  );
  lpf_delay #(.WIDTH(CTX_W), .DEPTH(MUL_LAT)) u_dly_ctx_p (
    .clk_i(clk_i), .en_i(adv), .d_i(g_ctx_q), .q_o(ctx_p)
  );

  always_comb begin
    ctx_pm     = ctx_p;
    ctx_pm.sat = ctx_p.sat | satp;
  end

  // Force components, one lane per axis
  logic [2:0][63:0] fk;
  logic [2:0] fsat;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    lpf_mulsat #(.SH(COORD_FRAC_BITS + 8)) u_mul_f (
      .clk_i(clk_i), .en_i(adv), .a_i(fp), .b_i(64'(ctx_pm.ad[k])),
      .lim_i((ctx_pm.neg ^ ctx_pm.dneg[k]) ? NEG47 : POS47),
      .res_o(fk[k]), .sat_o(fsat[k])
    );
  end

  lpf_delay #(.WIDTH(CTX_W), .DEPTH(MUL_LAT)) u_dly_ctx_h (
    .clk_i(clk_i), .en_i(adv), .d_i(ctx_pm), .q_o(ctx_h)
  );
  lpf_delay #(.WIDTH(65), .DEPTH(MUL_LAT)) u_dly_eng (
    .clk_i(clk_i), .en_i(adv), .d_i({sate, eng}), .q_o({esat_h, eng_h})
  );

  // Output stage: apply signs, merge flags, override coincident atoms
  logic [2:0][OUT_W-1:0] force_d, force_q;
  logic [OUT_W-1:0] energy_d, energy_q;
  logic zero_d, zero_q, sat_d, sat_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      force_d[k] = (ctx_h.neg ^ ctx_h.dneg[k]) ? (48'd0 - fk[k][47:0]) : fk[k][47:0];
    end
    if (ctx_h.en) begin
      energy_d = ctx_h.eneg ? (48'd0 - eng_h[47:0]) : eng_h[47:0];
    end else begin
      energy_d = '0;
    end
    sat_d  = ctx_h.sat | (|fsat) | (ctx_h.en & esat_h);
    zero_d = ctx_h.zero;
    if (ctx_h.zero) begin
      for (int k = 0; k < 3; k++) begin
        force_d[k] = POS47[47:0];
      end
      energy_d = ctx_h.en ? POS47[47:0] : 48'd0;
      sat_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      force_q  <= force_d;
      energy_q <= energy_d;
      zero_q   <= zero_d;
      sat_q    <= sat_d;
    end
  end

  assign m_axis_tdata = {energy_q, force_q[2], force_q[1], force_q[0]};
  assign m_axis_tuser = {sat_q, zero_q};

`ifndef SYNTHESIS
  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
    else $error("coincident atoms without saturated flag");

  a_zero_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[47:0] == POS47[47:0]) && (m_axis_tdata[95:48] == POS47[47:0]) &&
      (m_axis_tdata[143:96] == POS47[47:0]))
    else $error("coincident atoms without full-scale force");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> vld_q == $past(vld_q))
    else $error("valid pipe moved during a stall");

  a_cfg_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && (cfg_index_i >= CFG_NUM_REGS) |=>
      (rep_q == $past(rep_q)) && (att_q == $past(att_q)))
    else $error("write past the register list changed a coefficient");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_lj_pair_force_unit.sv =====
// Self-checking testbench for the Lennard-Jones pair force unit.
`default_nettype none

module tb_lj_pair_force_unit;
  import lpf_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned LATENCY = 2*FRAC + 65 + 6*4;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned NUM_RANDOM = 2000;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REP_00 = 4'd0, REG_ATT_00 = 4'd1, REG_REP_01 = 4'd2, REG_ATT_01 = 4'd3,
    REG_REP_10 = 4'd4, REG_ATT_10 = 4'd5, REG_REP_11 = 4'd6, REG_ATT_11 = 4'd7,
    REG_UNUSED = 4'd9
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] fx, fy, fz, sx, sy, sz;
    logic ft, st, en;
  } pair_t;

  typedef struct packed {
    logic [47:0] fx, fy, fz, energy;
    logic zero, sat;
  } force_t;

  logic clk_i, rst_ni;
  logic [191:0] s_axis_tdata;
  logic [2:0] s_axis_tuser;
  logic s_axis_tvalid, s_axis_tready;
  logic [191:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [COEF_W-1:0] cfg_data_i;

  lj_pair_force_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  logic [47:0] rep_tbl[4], att_tbl[4];
  force_t expected_forces[$];
  int errors = 0;
  int idle_cycles = 0;
  bit sink_stall_on = 1;

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Multiply, shift right and clip to a limit
  function automatic logic [63:0] mul_clip(input logic [63:0] a, input logic [63:0] b,
                                           input int sh, input logic [63:0] lim,
                                           inout bit sat);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    if (p > {64'd0, lim}) begin
      sat = 1;
      return lim;
    end
    return p[63:0];
  endfunction

  function automatic logic [47:0] apply_sign(input bit neg, input logic [63:0] mag);
    return neg ? 48'(-mag) : mag[47:0];
  endfunction

  // Expected force vector and energy for one atom pair
  function automatic force_t predict_force(input pair_t p);
    force_t r;
    logic signed [33:0] d[3];
    logic [63:0] ad[3];
    logic [127:0] dist_sq, q;
    logic [63:0] a, b, r2, r4, r6, ar, bs, mag, fl, fp, f, ea, eb, emag;
    bit sat, neg, fneg, eneg;
    int sel;
    sat = 0;
    sel = p.ft * 2 + p.st;
    a = {16'd0, rep_tbl[sel]};
    b = {16'd0, att_tbl[sel]};
    d[0] = 34'(p.fx) - 34'(p.sx);
    d[1] = 34'(p.fy) - 34'(p.sy);
    d[2] = 34'(p.fz) - 34'(p.sz);
    dist_sq = 0;
    for (int k = 0; k < 3; k++) begin
      ad[k] = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
      dist_sq += {64'd0, ad[k]} * {64'd0, ad[k]};
    end
    if (dist_sq == 0) begin
      r.fx = POS47[47:0]; r.fy = POS47[47:0]; r.fz = POS47[47:0];
      r.energy = p.en ? POS47[47:0] : 48'd0;
      r.zero = 1; r.sat = 1;
      return r;
    end
    q = (128'd1 << (2*FRAC + 32)) / dist_sq;
    if (q > {64'd0, ALL_ONES}) begin
      sat = 1;
      r2 = ALL_ONES;
    end else r2 = q[63:0];
    r4 = mul_clip(r2, r2, 32, ALL_ONES, sat);
    r6 = mul_clip(r4, r2, 32, ALL_ONES, sat);
    ar = mul_clip(a, r6, 24, MAG62, sat);
    bs = b << 8;
    neg = ar < bs;
    mag = neg ? bs - ar : ar - bs;
    fl = mul_clip(r6, mag, 32, MAG62, sat);
    fp = mul_clip(fl, r2, 32, MAG62, sat);
    fneg = neg != (d[0] < 0);
    f = mul_clip(fp, ad[0], FRAC + 8, fneg ? NEG47 : POS47, sat);
    r.fx = apply_sign(fneg, f);
    fneg = neg != (d[1] < 0);
    f = mul_clip(fp, ad[1], FRAC + 8, fneg ? NEG47 : POS47, sat);
    r.fy = apply_sign(fneg, f);
    fneg = neg != (d[2] < 0);
    f = mul_clip(fp, ad[2], FRAC + 8, fneg ? NEG47 : POS47, sat);
    r.fz = apply_sign(fneg, f);
    if (p.en) begin
      ea = ar / 12;
      eb = bs / 6;
      eneg = ea < eb;
      emag = eneg ? eb - ea : ea - eb;
      r.energy = apply_sign(eneg, mul_clip(r6, emag, 40, eneg ? NEG47 : POS47, sat));
    end else r.energy = 0;
    r.zero = 0;
    r.sat = sat;
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx < CFG_NUM_REGS) begin
      if (idx[0] == 0) rep_tbl[idx >> 1] = val;
      else att_tbl[idx >> 1] = val;
    end
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  // Drop the input valid and let the pipeline drain before touching coefficients
  task automatic wait_drained();
    s_axis_tvalid <= 0;
    while (expected_forces.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Hold valid across back-to-back beats; drop it only for a gap
  task automatic send_pair(input pair_t p, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {p.sz, p.sy, p.sx, p.fz, p.fy, p.fx};
    s_axis_tuser <= {p.en, p.st, p.ft};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_forces = {expected_forces, predict_force(p)};
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'sh7FFFFFFF - $urandom_range(3);
      default: return $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
    endcase
  endfunction

  function automatic logic [47:0] rand_coef();
    case ($urandom_range(4))
      0: return 48'({$urandom, $urandom});
      1: return 48'hFFFFFFFFFFFF;
      2: return 48'd0;
      default: return 48'($urandom_range(0, 32'h00FFFFFF));
    endcase
  endfunction

  task automatic program_all(input int mode);
    for (int i = 0; i < 8; i++)
      write_reg(i[CFG_IDX_W-1:0], mode == 0 ? 48'd0 : mode == 1 ? 48'hFFFFFFFFFFFF
                : rand_coef());
  endtask

  // Directed rows: pair plus the result where it is obvious
  typedef struct {
    pair_t p;
    bit known;
    force_t want;
  } row_t;

  // Result sink with random stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        force_t got, exp_r;
        got = {m_axis_tdata[47:0], m_axis_tdata[95:48], m_axis_tdata[143:96],
               m_axis_tdata[191:144], m_axis_tuser[0], m_axis_tuser[1]};
        if (expected_forces.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_r = expected_forces.pop_front();
          if (got.fx !== exp_r.fx) begin
            $display("%0t: force_x exp %h got %h", $time, exp_r.fx, got.fx);
            errors++;
          end
          if (got.fy !== exp_r.fy) begin
            $display("%0t: force_y exp %h got %h", $time, exp_r.fy, got.fy);
            errors++;
          end
          if (got.fz !== exp_r.fz) begin
            $display("%0t: force_z exp %h got %h", $time, exp_r.fz, got.fz);
            errors++;
          end
          if (got.energy !== exp_r.energy) begin
            $display("%0t: energy exp %h got %h", $time, exp_r.energy, got.energy);
            errors++;
          end
          if (got.zero !== exp_r.zero) begin
            $display("%0t: zero_distance exp %b got %b", $time, exp_r.zero, got.zero);
            errors++;
          end
          if (got.sat !== exp_r.sat) begin
            $display("%0t: saturated exp %b got %b", $time, exp_r.sat, got.sat);
            errors++;
          end
        end
      end
      m_axis_tready <= !sink_stall_on || $urandom_range(9) > 2 ||
                       ($urandom_range(99) == 0 ? 1'b0 : m_axis_tready);
    end
  end

  // Count cycles with no beat on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_lj_pair_force_unit failed");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    pair_t p;
    logic [47:0] pos_max;
    int sent;
    pos_max = POS47[47:0];
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
    m_axis_tready = 0;
    cfg_valid_i = 0; cfg_index_i = 0; cfg_data_i = 0;
    for (int i = 0; i < 4; i++) begin
      rep_tbl[i] = 0;
      att_tbl[i] = 0;
    end
    rst_ni = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // After reset: coefficients are zero, so coincident atoms still saturate
    rw.known = 1;
    rw.p = '{fx: 0, fy: 0, fz: 0, sx: 0, sy: 0, sz: 0, ft: 0, st: 0, en: 1};
    rw.want = '{fx: pos_max, fy: pos_max, fz: pos_max, energy: pos_max, zero: 1, sat: 1};
    rows = {rows, rw};
    rw.p = '{fx: 32'sh7FFFFFFF, fy: 32'sh7FFFFFFF, fz: 5, sx: 32'sh7FFFFFFF,
             sy: 32'sh7FFFFFFF, sz: 5, ft: 1, st: 1, en: 0};
    rw.want = '{fx: pos_max, fy: pos_max, fz: pos_max, energy: 0, zero: 1, sat: 1};
    rows = {rows, rw};
    rw.known = 0;
    rw.p = '{fx: 32'sh7FFFFFFF, fy: 32'sh80000000, fz: 32'sh7FFFFFFF,
             sx: 32'sh80000000, sy: 32'sh7FFFFFFF, sz: 32'sh80000000, ft: 0, st: 1, en: 1};
    rows = {rows, rw};
    rw.p = '{fx: 32'h10000, fy: 0, fz: 0, sx: 0, sy: 0, sz: 0, ft: 1, st: 0, en: 1};
    rows = {rows, rw};
    rw.p = '{fx: 1, fy: -1, fz: 1, sx: 0, sy: 0, sz: 0, ft: 0, st: 0, en: 1};
    rows = {rows, rw};
    rw.p = '{fx: -32'sh28000, fy: 32'sh18000, fz: -32'sh8000, sx: 0, sy: 0, sz: 0,
             ft: 1, st: 1, en: 1};
    rows = {rows, rw};

    // Walk the table under several coefficient sets, extremes among them
    for (int mode = 0; mode < 3; mode++) begin
      if (mode != 0) begin
        wait_drained();
        program_all(mode);
      end
      foreach (rows[i]) begin
        send_pair(rows[i].p, 0);
        if (rows[i].known && mode == 0) begin
          expected_forces[expected_forces.size() - 1] = rows[i].want;
        end
      end
    end
    wait_drained();
    write_reg(REG_UNUSED, 48'hFFFFFFFFFFFF);
    write_reg(REG_REP_00, 48'h000001000000);
    write_reg(REG_ATT_00, 48'h000000800000);

    // Random pairs, with coefficient changes between phases
    sent = 0;
    while (sent < NUM_RANDOM) begin
      sink_stall_on = ($urandom_range(3) != 0);
      for (int j = 0; j < 250; j++) begin
        p.sx = rand_coord(); p.sy = rand_coord(); p.sz = rand_coord();
        if ($urandom_range(3) == 0) begin
          p.fx = $urandom; p.fy = $urandom; p.fz = $urandom;
        end else begin
          p.fx = p.sx + $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
          p.fy = p.sy + $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
          p.fz = p.sz + $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
        end
        if ($urandom_range(40) == 0) begin
          p.fx = p.sx; p.fy = p.sy; p.fz = p.sz;
        end
        p.ft = 1'($urandom); p.st = 1'($urandom); p.en = 1'($urandom);
        send_pair(p, sink_stall_on);
        sent++;
      end
      wait_drained();
      program_all(2);
    end

    // Drain and finish
    while (expected_forces.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0) $display("tb_lj_pair_force_unit passed");
    else $display("tb_lj_pair_force_unit failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/lpf_pkg.sv
rtl/core/lpf_delay.sv
rtl/core/lpf_mulsat.sv
rtl/core/lpf_recip.sv
rtl/core/lj_pair_force_unit.sv
sim/tb_lj_pair_force_unit.sv
